### rtl/axis_rotation_3d_unit_macros.svh
`ifndef AXIS_ROTATION_3D_UNIT_MACROS_SVH
`define AXIS_ROTATION_3D_UNIT_MACROS_SVH

// same-cycle implication, off while reset is held
`define AROT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AROT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// implication a fixed number of cycles later
`define AROT_ASSERT_LATER(label, clk, rst_n, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

### rtl/arot_pkg.sv
package arot_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int TRIG_WIDTH     = 16;
  localparam int ANGLE_WIDTH    = 16;
  localparam int CMD_WIDTH      = 2;
  localparam int AXES           = 3;
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 4;

  localparam int PROD_WIDTH = COORD_WIDTH + TRIG_WIDTH;
  localparam int SUM_WIDTH  = PROD_WIDTH + 1;
  localparam int TRIG_MAX   = (1 << (TRIG_WIDTH - 1)) - 1;
  localparam int TRIG_SHIFT = 31 - TRIG_WIDTH;

  // shared multiplier of the sine sequencer
  localparam int MUL_WIDTH = 32;
  localparam int Q30_SHIFT = 30;
  localparam int X_SHIFT   = 14;
  localparam logic [MUL_WIDTH-1:0] Q30_ONE     = 32'h4000_0000;
  localparam logic [MUL_WIDTH-1:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [ANGLE_WIDTH-1:0] QUARTER_TURN = 16'h4000;

  // odd series of the quarter-wave sine, innermost term first
  localparam int SERIES_TERMS = 6;
  localparam int TERM_WIDTH   = $clog2(SERIES_TERMS);
  localparam int RECIP_SHIFT  = 34;
  localparam logic [7:0] SERIES_DIV [SERIES_TERMS] = '{
    8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
  };
  // floor(2^34 / d): quotient estimate is low by at most one
  localparam logic [MUL_WIDTH-1:0] SERIES_RECIP [SERIES_TERMS] = '{
    MUL_WIDTH'((64'd1 << RECIP_SHIFT) / 64'd156),
    MUL_WIDTH'((64'd1 << RECIP_SHIFT) / 64'd110),
    MUL_WIDTH'((64'd1 << RECIP_SHIFT) / 64'd72),
    MUL_WIDTH'((64'd1 << RECIP_SHIFT) / 64'd42),
    MUL_WIDTH'((64'd1 << RECIP_SHIFT) / 64'd20),
    MUL_WIDTH'((64'd1 << RECIP_SHIFT) / 64'd6)
  };

  // axis code; register index i holds the angle of axis i
  typedef enum logic [CMD_WIDTH-1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef struct packed {
    logic signed [TRIG_WIDTH-1:0] sin_v;
    logic signed [TRIG_WIDTH-1:0] cos_v;
  } axis_trig_t;

  typedef axis_trig_t [AXES-1:0] trig_bank_t;
  typedef logic [AXES-1:0][ANGLE_WIDTH-1:0] angle_bank_t;

  typedef struct packed {
    logic                   en;
    axis_t                  axis;
    logic [ANGLE_WIDTH-1:0] angle;
  } angle_wr_t;

  function automatic axis_trig_t pick_trig(trig_bank_t bank, axis_t axis);
    axis_trig_t sel;
    case (axis)
      AXIS_X:  sel = bank[0];
      AXIS_Y:  sel = bank[1];
      AXIS_Z:  sel = bank[2];
      default: sel = '0;
    endcase
    return sel;
  endfunction

endpackage

### rtl/arot_trig_unit.sv
`include "axis_rotation_3d_unit_macros.svh"

module arot_trig_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  arot_pkg::angle_wr_t   wr_i,
  output arot_pkg::angle_bank_t angle_o,
  output arot_pkg::trig_bank_t  trig_o,
  output logic                  busy_o
);
  import arot_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL_X,
    ST_GET_X,
    ST_MUL_X2,
    ST_GET_X2,
    ST_MUL_T,
    ST_GET_V,
    ST_MUL_R,
    ST_GET_Q,
    ST_MUL_D,
    ST_FIX,
    ST_MUL_S,
    ST_GET_S
  } state_t;

  localparam logic [TERM_WIDTH-1:0] TERM_LAST = TERM_WIDTH'(SERIES_TERMS - 1);
  localparam logic [14:0] QUARTER_U = 15'h4000;
  localparam logic [TRIG_WIDTH-1:0] TRIG_FULL = TRIG_WIDTH'(TRIG_MAX);
  localparam logic signed [TRIG_WIDTH-1:0] TRIG_MIN_CODE = {1'b1, {(TRIG_WIDTH-1){1'b0}}};
  localparam logic [32:0] ROUND_HALF = 33'd1 << (TRIG_SHIFT - 1);

  state_t                  state_r, state_nxt;
  logic [AXES-1:0]         pending_r, pending_nxt;
  axis_t                   axis_r, axis_nxt;
  logic                    phase_r, phase_nxt;
  logic [TERM_WIDTH-1:0]   term_r, term_nxt;
  angle_bank_t             angle_r, angle_nxt;
  trig_bank_t              bank_r, bank_nxt;

  logic [ANGLE_WIDTH-1:0]  ang_r, ang_nxt;
  logic [1:0]              quad_r, quad_nxt;
  logic [14:0]             u_r, u_nxt;
  logic [MUL_WIDTH-1:0]    x_r, x_nxt;
  logic [MUL_WIDTH-1:0]    x2_r, x2_nxt;
  logic [MUL_WIDTH-1:0]    t_r, t_nxt;
  logic [MUL_WIDTH-1:0]    v_r, v_nxt;
  logic [MUL_WIDTH-1:0]    q_r, q_nxt;
  logic [2*MUL_WIDTH-1:0]  prod_r;

  logic [MUL_WIDTH-1:0]    mul_a, mul_b;
  logic [AXES-1:0]         wr_set, pend_clr;
  logic [ANGLE_WIDTH-1:0]  turn;
  logic [MUL_WIDTH-1:0]    rem, qfix, div_v;
  logic [32:0]             rnd, mag;
  logic [TRIG_WIDTH-1:0]   tval;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    phase_nxt = phase_r;
    term_nxt  = term_r;
    angle_nxt = angle_r;
    bank_nxt  = bank_r;
    ang_nxt   = ang_r;
    quad_nxt  = quad_r;
    u_nxt     = u_r;
    x_nxt     = x_r;
    x2_nxt    = x2_r;
    t_nxt     = t_r;
    v_nxt     = v_r;
    q_nxt     = q_r;
    mul_a     = '0;
    mul_b     = '0;
    wr_set    = '0;
    pend_clr  = '0;
    turn      = '0;
    rem       = '0;
    qfix      = '0;
    div_v     = MUL_WIDTH'(SERIES_DIV[term_r]);
    rnd       = '0;
    mag       = '0;
    tval      = '0;

    if (wr_i.en) begin
      case (wr_i.axis)
        AXIS_X: begin
          angle_nxt[0] = wr_i.angle;
          wr_set[0]    = 1'b1;
        end
        AXIS_Y: begin
          angle_nxt[1] = wr_i.angle;
          wr_set[1]    = 1'b1;
        end
        AXIS_Z: begin
          angle_nxt[2] = wr_i.angle;
          wr_set[2]    = 1'b1;
        end
        default: begin
          angle_nxt = angle_r;
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        // lowest pending axis first; a write during the run queues a rerun
        if (pending_r[0]) begin
          axis_nxt    = AXIS_X;
          ang_nxt     = angle_r[0];
          pend_clr[0] = 1'b1;
        end else if (pending_r[1]) begin
          axis_nxt    = AXIS_Y;
          ang_nxt     = angle_r[1];
          pend_clr[1] = 1'b1;
        end else if (pending_r[2]) begin
          axis_nxt    = AXIS_Z;
          ang_nxt     = angle_r[2];
          pend_clr[2] = 1'b1;
        end
        if (|pending_r) begin
          phase_nxt = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // cosine is the sine a quarter turn ahead; fold to a quarter wave
        turn      = ang_r + (phase_r ? QUARTER_TURN : '0);
        quad_nxt  = turn[15:14];
        u_nxt     = turn[14] ? (QUARTER_U - {1'b0, turn[13:0]}) : {1'b0, turn[13:0]};
        state_nxt = ST_MUL_X;
      end
      ST_MUL_X: begin
        mul_a     = MUL_WIDTH'(u_r);
        mul_b     = HALF_PI_Q30;
        state_nxt = ST_GET_X;
      end
      ST_GET_X: begin
        x_nxt     = MUL_WIDTH'(prod_r >> X_SHIFT);
        state_nxt = ST_MUL_X2;
      end
      ST_MUL_X2: begin
        mul_a     = x_r;
        mul_b     = x_r;
        state_nxt = ST_GET_X2;
      end
      ST_GET_X2: begin
        x2_nxt    = MUL_WIDTH'(prod_r >> Q30_SHIFT);
        t_nxt     = Q30_ONE;
        term_nxt  = '0;
        state_nxt = ST_MUL_T;
      end
      ST_MUL_T: begin
        mul_a     = x2_r;
        mul_b     = t_r;
        state_nxt = ST_GET_V;
      end
      ST_GET_V: begin
        v_nxt     = MUL_WIDTH'(prod_r >> Q30_SHIFT);
        state_nxt = ST_MUL_R;
      end
      ST_MUL_R: begin
        mul_a     = v_r;
        mul_b     = SERIES_RECIP[term_r];
        state_nxt = ST_GET_Q;
      end
      ST_GET_Q: begin
        q_nxt     = MUL_WIDTH'(prod_r >> RECIP_SHIFT);
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        mul_a     = q_r;
        mul_b     = div_v;
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        // bump the estimate when the remainder still holds a divisor
        rem   = v_r - prod_r[MUL_WIDTH-1:0];
        qfix  = q_r + ((rem >= div_v) ? MUL_WIDTH'(1) : MUL_WIDTH'(0));
        t_nxt = Q30_ONE - qfix;
        if (term_r == TERM_LAST) begin
          state_nxt = ST_MUL_S;
        end else begin
          term_nxt  = term_r + 1'b1;
          state_nxt = ST_MUL_T;
        end
      end
      ST_MUL_S: begin
        mul_a     = x_r;
        mul_b     = t_r;
        state_nxt = ST_GET_S;
      end
      ST_GET_S: begin
        rnd  = 33'(prod_r >> Q30_SHIFT) + ROUND_HALF;
        mag  = rnd >> TRIG_SHIFT;
        tval = (mag > 33'(TRIG_MAX)) ? TRIG_FULL : TRIG_WIDTH'(mag);
        if (quad_r[1]) begin
          tval = -tval;
        end
        case (axis_r)
          AXIS_X: begin
            if (phase_r) bank_nxt[0].cos_v = tval;
            else         bank_nxt[0].sin_v = tval;
          end
          AXIS_Y: begin
            if (phase_r) bank_nxt[1].cos_v = tval;
            else         bank_nxt[1].sin_v = tval;
          end
          AXIS_Z: begin
            if (phase_r) bank_nxt[2].cos_v = tval;
            else         bank_nxt[2].sin_v = tval;
          end
          default: begin
            bank_nxt = bank_r;
          end
        endcase
        if (phase_r) begin
          state_nxt = ST_IDLE;
        end else begin
          phase_nxt = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    pending_nxt = (pending_r & ~pend_clr) | wr_set;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pending_r <= '0;
      axis_r    <= AXIS_X;
      phase_r   <= 1'b0;
      term_r    <= '0;
      angle_r   <= '0;
      for (int i = 0; i < AXES; i++) begin
        bank_r[i].sin_v <= '0;
        bank_r[i].cos_v <= TRIG_FULL;
      end
    end else begin
      state_r   <= state_nxt;
      pending_r <= pending_nxt;
      axis_r    <= axis_nxt;
      phase_r   <= phase_nxt;
      term_r    <= term_nxt;
      angle_r   <= angle_nxt;
      bank_r    <= bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ang_r  <= ang_nxt;
    quad_r <= quad_nxt;
    u_r    <= u_nxt;
    x_r    <= x_nxt;
    x2_r   <= x2_nxt;
    t_r    <= t_nxt;
    v_r    <= v_nxt;
    q_r    <= q_nxt;
    prod_r <= mul_a * mul_b;
  end

  assign angle_o = angle_r;
  assign trig_o  = bank_r;
  assign busy_o  = (state_r != ST_IDLE) || (|pending_r);

  `AROT_ASSERT_NEXT(a_wr_busy, clk, rst_n, wr_i.en && (wr_i.axis != AXIS_NONE), busy_o, "angle write did not raise busy")
  `AROT_ASSERT_SAME(a_no_min_code, clk, rst_n, 1'b1, (bank_r[0].sin_v != TRIG_MIN_CODE) && (bank_r[0].cos_v != TRIG_MIN_CODE) && (bank_r[1].sin_v != TRIG_MIN_CODE) && (bank_r[1].cos_v != TRIG_MIN_CODE) && (bank_r[2].sin_v != TRIG_MIN_CODE) && (bank_r[2].cos_v != TRIG_MIN_CODE), "trig value outside symmetric range")
  `AROT_ASSERT_NEXT(a_series_end, clk, rst_n, (state_r == ST_FIX) && (term_r == TERM_LAST), state_r == ST_MUL_S, "series did not close after last term")
  `AROT_ASSERT_NEXT(a_cos_follows, clk, rst_n, (state_r == ST_GET_S) && !phase_r, (state_r == ST_LOAD) && phase_r, "cosine pass did not follow sine")

endmodule

### rtl/arot_mix_lane.sv
module arot_mix_lane (
  input  logic                                  clk,
  input  logic signed [arot_pkg::COORD_WIDTH-1:0] p_i,
  input  logic signed [arot_pkg::COORD_WIDTH-1:0] q_i,
  input  logic signed [arot_pkg::TRIG_WIDTH-1:0]  cp_i,
  input  logic signed [arot_pkg::TRIG_WIDTH-1:0]  cq_i,
  output logic signed [arot_pkg::COORD_WIDTH-1:0] res_o,
  output logic                                  sat_o
);
  import arot_pkg::*;

  localparam int SHIFT = TRIG_WIDTH - 1;
  localparam logic signed [SUM_WIDTH-1:0] ROUND_HALF =
    {{(SUM_WIDTH-TRIG_WIDTH+1){1'b0}}, 1'b1, {(TRIG_WIDTH-2){1'b0}}};
  localparam logic signed [COORD_WIDTH-1:0] POS_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] NEG_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [PROD_WIDTH-1:0]  prod_p_r, prod_p_nxt;
  logic signed [PROD_WIDTH-1:0]  prod_q_r, prod_q_nxt;
  logic signed [SUM_WIDTH-1:0]   sum_r, sum_nxt;
  logic signed [COORD_WIDTH-1:0] res_r, res_nxt;
  logic                          sat_r, sat_nxt;
  logic [2:0]                    top_bits;
  logic                          fits;

  always_comb begin
    prod_p_nxt = p_i * cp_i;
    prod_q_nxt = q_i * cq_i;
    sum_nxt    = SUM_WIDTH'(prod_p_r) + SUM_WIDTH'(prod_q_r) + ROUND_HALF;

    // the rounded value fits when everything from its sign bit up agrees
    top_bits = sum_r[SUM_WIDTH-1:SHIFT+COORD_WIDTH-1];
    fits     = (&top_bits) || !(|top_bits);
    if (fits) begin
      res_nxt = sum_r[SHIFT+COORD_WIDTH-1:SHIFT];
    end else begin
      res_nxt = sum_r[SUM_WIDTH-1] ? NEG_MIN : POS_MAX;
    end
    sat_nxt = !fits;
  end

  always_ff @(posedge clk) begin
    prod_p_r <= prod_p_nxt;
    prod_q_r <= prod_q_nxt;
    sum_r    <= sum_nxt;
    res_r    <= res_nxt;
    sat_r    <= sat_nxt;
  end

  assign res_o = res_r;
  assign sat_o = sat_r;

endmodule

### rtl/arot_pipe.sv
`include "axis_rotation_3d_unit_macros.svh"

module arot_pipe (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  accept_i,
  input  arot_pkg::axis_t                       cmd_i,
  input  logic signed [arot_pkg::COORD_WIDTH-1:0] x_i,
  input  logic signed [arot_pkg::COORD_WIDTH-1:0] y_i,
  input  logic signed [arot_pkg::COORD_WIDTH-1:0] z_i,
  input  arot_pkg::trig_bank_t                  trig_i,
  output logic                                  out_valid_o,
  output logic signed [arot_pkg::COORD_WIDTH-1:0] out_x_o,
  output logic signed [arot_pkg::COORD_WIDTH-1:0] out_y_o,
  output logic signed [arot_pkg::COORD_WIDTH-1:0] out_z_o,
  output logic                                  out_sat_o
);
  import arot_pkg::*;

  localparam logic signed [COORD_WIDTH-1:0] POS_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] NEG_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    axis_t                   cmd;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } point_t;

  logic   v1_r, v2_r, v3_r, v4_r;
  point_t pt1_r, pt2_r, pt3_r, pt4_r, pt_nxt;

  logic signed [COORD_WIDTH-1:0] p1_r, q1_r, p_nxt, q_nxt;
  logic signed [TRIG_WIDTH-1:0]  cpa1_r, cqa1_r, cpb1_r, cqb1_r;
  logic signed [TRIG_WIDTH-1:0]  cpa_nxt, cqa_nxt, cpb_nxt, cqb_nxt;
  axis_trig_t                    sel;
  logic signed [TRIG_WIDTH-1:0]  neg_sin;

  logic signed [COORD_WIDTH-1:0] res_a, res_b;
  logic                          sat_a, sat_b;

  // entry stage: route the two rotated coordinates and their coefficients
  always_comb begin
    sel     = pick_trig(trig_i, cmd_i);
    neg_sin = -sel.sin_v;
    pt_nxt  = '{cmd: cmd_i, x: x_i, y: y_i, z: z_i};
    case (cmd_i)
      AXIS_X: begin
        p_nxt = y_i;
        q_nxt = z_i;
      end
      AXIS_Y: begin
        p_nxt = x_i;
        q_nxt = z_i;
      end
      default: begin
        p_nxt = x_i;
        q_nxt = y_i;
      end
    endcase
    cpa_nxt = sel.cos_v;
    cqa_nxt = (cmd_i == AXIS_Y) ? sel.sin_v : neg_sin;
    cpb_nxt = (cmd_i == AXIS_Y) ? neg_sin : sel.sin_v;
    cqb_nxt = sel.cos_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    pt1_r  <= pt_nxt;
    pt2_r  <= pt1_r;
    pt3_r  <= pt2_r;
    pt4_r  <= pt3_r;
    p1_r   <= p_nxt;
    q1_r   <= q_nxt;
    cpa1_r <= cpa_nxt;
    cqa1_r <= cqa_nxt;
    cpb1_r <= cpb_nxt;
    cqb1_r <= cqb_nxt;
  end

  arot_mix_lane u_lane_a (
    .clk   (clk),
    .p_i   (p1_r),
    .q_i   (q1_r),
    .cp_i  (cpa1_r),
    .cq_i  (cqa1_r),
    .res_o (res_a),
    .sat_o (sat_a)
  );

  arot_mix_lane u_lane_b (
    .clk   (clk),
    .p_i   (p1_r),
    .q_i   (q1_r),
    .cp_i  (cpb1_r),
    .cq_i  (cqb1_r),
    .res_o (res_b),
    .sat_o (sat_b)
  );

  // put the lane results back on their axes; the rotation axis passes through
  always_comb begin
    out_x_o   = pt4_r.x;
    out_y_o   = pt4_r.y;
    out_z_o   = pt4_r.z;
    out_sat_o = sat_a || sat_b;
    case (pt4_r.cmd)
      AXIS_X: begin
        out_y_o = res_a;
        out_z_o = res_b;
      end
      AXIS_Y: begin
        out_x_o = res_a;
        out_z_o = res_b;
      end
      AXIS_Z: begin
        out_x_o = res_a;
        out_y_o = res_b;
      end
      default: begin
        out_sat_o = 1'b0;
      end
    endcase
  end

  assign out_valid_o = v4_r;

  `AROT_ASSERT_LATER(a_latency, clk, rst_n, accept_i, 4, v4_r, "accepted beat did not reach the output stage")
  `AROT_ASSERT_SAME(a_sat_axis, clk, rst_n, out_valid_o && out_sat_o, pt4_r.cmd != AXIS_NONE, "saturation flagged on a pass-through beat")
  `AROT_ASSERT_SAME(a_sat_clamp, clk, rst_n, v4_r && sat_a, (res_a == POS_MAX) || (res_a == NEG_MIN), "saturated lane result is not a range limit")

endmodule

### rtl/axis_rotation_3d_unit.sv
// out_valid strobes once an accepted point has passed the entry, product, sum and result registers.
// Throughput: one point per cycle while busy is low; the four-stage rotation pipeline
// never stalls, and each result must be taken in the cycle it is shown.
// An angle write raises busy, which stays high while the shared multiplier
// of the sine sequencer evaluates that axis's sine and cosine; queued axes run in turn.
// Reset (synchronous, rst_n low): angles zero, sines zero, cosines full scale, pipeline empty.
module axis_rotation_3d_unit (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  logic [arot_pkg::CMD_WIDTH-1:0]           in_cmd,
  input  logic signed [arot_pkg::COORD_WIDTH-1:0]  in_x,
  input  logic signed [arot_pkg::COORD_WIDTH-1:0]  in_y,
  input  logic signed [arot_pkg::COORD_WIDTH-1:0]  in_z,
  output logic                                     out_valid,
  output logic signed [arot_pkg::COORD_WIDTH-1:0]  out_x,
  output logic signed [arot_pkg::COORD_WIDTH-1:0]  out_y,
  output logic signed [arot_pkg::COORD_WIDTH-1:0]  out_z,
  output logic                                     out_saturated,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [arot_pkg::APB_ADDR_WIDTH-1:0]      paddr,
  input  logic [arot_pkg::APB_DATA_WIDTH-1:0]      pwdata,
  output logic [arot_pkg::APB_DATA_WIDTH-1:0]      prdata,
  output logic                                     pready
);
  import arot_pkg::*;

  angle_wr_t   wr;
  angle_bank_t angles;
  trig_bank_t  trig;
  axis_t       reg_sel;
  logic        accept;

  assign pready  = 1'b1;
  assign reg_sel = axis_t'(paddr[APB_ADDR_WIDTH-1:2]);

  always_comb begin
    wr.en    = psel && penable && pwrite && pready;
    wr.axis  = reg_sel;
    wr.angle = pwdata[ANGLE_WIDTH-1:0];
  end

  always_comb begin
    case (reg_sel)
      AXIS_X:  prdata = APB_DATA_WIDTH'(angles[0]);
      AXIS_Y:  prdata = APB_DATA_WIDTH'(angles[1]);
      AXIS_Z:  prdata = APB_DATA_WIDTH'(angles[2]);
      default: prdata = '0;
    endcase
  end

  assign accept = start && !busy;

  arot_trig_unit u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_i    (wr),
    .angle_o (angles),
    .trig_o  (trig),
    .busy_o  (busy)
  );

  arot_pipe u_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept_i    (accept),
    .cmd_i       (axis_t'(in_cmd)),
    .x_i         (in_x),
    .y_i         (in_y),
    .z_i         (in_z),
    .trig_i      (trig),
    .out_valid_o (out_valid),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_z_o     (out_z),
    .out_sat_o   (out_saturated)
  );

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import arot_pkg::*;

  localparam int REG_ANGLE_X = 0;
  localparam int REG_ANGLE_Y = 1;
  localparam int REG_ANGLE_Z = 2;
  localparam int REG_SPARE   = 3;
  localparam int REG_STRIDE  = 4;

  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_PER_SET = 145;
  localparam int SET_COUNT      = 8;

  localparam int QUARTER_STEPS = 1 << (ANGLE_WIDTH - 2);
  localparam int TRIG_LIMIT    = (1 << (TRIG_WIDTH - 1)) - 1;
  localparam int SINE_DROP     = 31 - TRIG_WIDTH;
  localparam int Q30_BITS      = 30;
  localparam longint unsigned Q30_UNIT    = 64'd1 << Q30_BITS;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned SERIES_DIVISOR [6] = '{156, 110, 72, 42, 20, 6};

  localparam logic signed [COORD_WIDTH-1:0] COORD_TOP    = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_BOTTOM = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam longint ROUND_HALF = longint'(1) <<< (TRIG_WIDTH - 2);

  localparam bit [ANGLE_WIDTH-1:0] FIXED_ANGLES [4][AXES] = '{
    '{16'd8192,  16'd0,     16'd57344},
    '{16'd65535, 16'd1,     16'd32768},
    '{16'd16384, 16'd49152, 16'd32767},
    '{16'd32769, 16'd16383, 16'd49151}
  };

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    bit                            sat;
  } rotated_point_t;

  class rotation_tracker;
    bit [ANGLE_WIDTH-1:0] angle [AXES];
    int                   sin_q [AXES];
    int                   cos_q [AXES];
    rotated_point_t       pending_points [$];
    int unsigned          mismatches;

    function longint unsigned quarter_wave(int unsigned u);
      longint unsigned x, x2, t;
      x = (64'(u) * PI_HALF_Q30) >> (ANGLE_WIDTH - 2);
      x2 = (x * x) >> Q30_BITS;
      t = Q30_UNIT;
      for (int i = 0; i < 6; i++)
        t = Q30_UNIT - ((x2 * t) >> Q30_BITS) / SERIES_DIVISOR[i];
      return (x * t) >> Q30_BITS;
    endfunction

    function int turn_sine(bit [ANGLE_WIDTH-1:0] a);
      bit [1:0]               quad;
      bit [ANGLE_WIDTH-3:0]   r;
      int unsigned            u;
      longint unsigned        s;
      int                     v;
      quad = a[ANGLE_WIDTH-1 -: 2];
      r = a[ANGLE_WIDTH-3:0];
      // mirror odd quadrants onto the rising quarter wave
      u = quad[0] ? QUARTER_STEPS - r : r;
      s = (quarter_wave(u) + (64'd1 << (SINE_DROP - 1))) >> SINE_DROP;
      v = (s > 64'(TRIG_LIMIT)) ? TRIG_LIMIT : int'(s);
      return quad[1] ? -v : v;
    endfunction

    function void load_angle(int axis, bit [ANGLE_WIDTH-1:0] a);
      angle[axis] = a;
      sin_q[axis] = turn_sine(a);
      cos_q[axis] = turn_sine(ANGLE_WIDTH'(a + QUARTER_STEPS));
    endfunction

    function void clear();
      for (int i = 0; i < AXES; i++) load_angle(i, '0);
      pending_points.delete();
      mismatches = 0;
    endfunction

    function int outstanding();
      return pending_points.size();
    endfunction

    // round(p*cp + q*cq) back to Q16.16, clamp to the coordinate range
    function logic signed [COORD_WIDTH-1:0] rotate_term(
      input logic signed [COORD_WIDTH-1:0] p, input int cp,
      input logic signed [COORD_WIDTH-1:0] q, input int cq,
      inout bit clamped);
      longint acc;
      acc = (longint'(p) * cp + longint'(q) * cq + ROUND_HALF) >>> (TRIG_WIDTH - 1);
      if (acc > longint'(COORD_TOP)) begin
        clamped = 1'b1;
        return COORD_TOP;
      end
      if (acc < longint'(COORD_BOTTOM)) begin
        clamped = 1'b1;
        return COORD_BOTTOM;
      end
      return acc[COORD_WIDTH-1:0];
    endfunction

    function void note_point(axis_t cmd, logic signed [COORD_WIDTH-1:0] x,
                             logic signed [COORD_WIDTH-1:0] y,
                             logic signed [COORD_WIDTH-1:0] z);
      rotated_point_t r;
      bit             clamped;
      int             s, c;
      r.x = x;
      r.y = y;
      r.z = z;
      clamped = 1'b0;
      case (cmd)
        AXIS_X: begin
          s = sin_q[REG_ANGLE_X];
          c = cos_q[REG_ANGLE_X];
          r.y = rotate_term(y, c, z, -s, clamped);
          r.z = rotate_term(y, s, z, c, clamped);
        end
        AXIS_Y: begin
          s = sin_q[REG_ANGLE_Y];
          c = cos_q[REG_ANGLE_Y];
          r.x = rotate_term(x, c, z, s, clamped);
          r.z = rotate_term(x, -s, z, c, clamped);
        end
        AXIS_Z: begin
          s = sin_q[REG_ANGLE_Z];
          c = cos_q[REG_ANGLE_Z];
          r.x = rotate_term(x, c, y, -s, clamped);
          r.y = rotate_term(x, s, y, c, clamped);
        end
        default: ;
      endcase
      r.sat = clamped;
      pending_points.push_back(r);
    endfunction

    function void compare_field(string label, logic [COORD_WIDTH-1:0] want,
                                logic [COORD_WIDTH-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, actual %0d", $time, label,
                 $signed(want), $signed(got));
        mismatches++;
      end
    endfunction

    function void check_point(logic signed [COORD_WIDTH-1:0] x,
                              logic signed [COORD_WIDTH-1:0] y,
                              logic signed [COORD_WIDTH-1:0] z, logic sat);
      rotated_point_t want;
      if (pending_points.size() == 0) begin
        $display("%0t: result with no point outstanding, expected none, actual %0d %0d %0d %0b",
                 $time, x, y, z, sat);
        mismatches++;
        return;
      end
      want = pending_points.pop_front();
      compare_field("out_x", want.x, x);
      compare_field("out_y", want.y, y);
      compare_field("out_z", want.z, z);
      compare_field("out_saturated", COORD_WIDTH'(want.sat), COORD_WIDTH'(sat));
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [CMD_WIDTH-1:0]          in_cmd = '0;
  logic signed [COORD_WIDTH-1:0] in_x = '0;
  logic signed [COORD_WIDTH-1:0] in_y = '0;
  logic signed [COORD_WIDTH-1:0] in_z = '0;
  logic                          out_valid;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic                          out_saturated;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [APB_ADDR_WIDTH-1:0]     paddr = '0;
  logic [APB_DATA_WIDTH-1:0]     pwdata = '0;
  logic [APB_DATA_WIDTH-1:0]     prdata;
  logic                          pready;

  rotation_tracker tracker = new;
  bit              no_gaps = 1'b0;

  axis_rotation_3d_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_x          (in_x),
    .in_y          (in_y),
    .in_z          (in_z),
    .out_valid     (out_valid),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_saturated (out_saturated),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1)
        tracker.check_point(out_x, out_y, out_z, out_saturated);
      if (start === 1'b1 && busy === 1'b0)
        tracker.note_point(axis_t'(in_cmd), in_x, in_y, in_z);
    end
  end

  function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
    logic [COORD_WIDTH-1:0] raw;
    raw = $urandom;
    case ($urandom_range(9))
      0:       return COORD_TOP;
      1:       return COORD_BOTTOM;
      2:       return {{(COORD_WIDTH-10){raw[9]}}, raw[9:0]};
      3, 4:    return {{(COORD_WIDTH-24){raw[23]}}, raw[23:0]};
      default: return raw;
    endcase
  endfunction

  function automatic axis_t pick_axis();
    return ($urandom_range(9) == 0) ? AXIS_NONE : axis_t'($urandom_range(2));
  endfunction

  task automatic send_point(axis_t cmd, logic signed [COORD_WIDTH-1:0] x,
                            logic signed [COORD_WIDTH-1:0] y,
                            logic signed [COORD_WIDTH-1:0] z);
    int gap;
    if (!no_gaps && $urandom_range(99) < 32) begin
      gap = $urandom_range(1, 2);
      start <= 1'b0;
      in_cmd <= CMD_WIDTH'($urandom);
      in_x <= $urandom;
      in_y <= $urandom;
      in_z <= $urandom;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input int idx,
                            input logic [APB_DATA_WIDTH-1:0] wdata,
                            output logic [APB_DATA_WIDTH-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= APB_ADDR_WIDTH'(idx * REG_STRIDE);
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_angle(int idx, bit [ANGLE_WIDTH-1:0] a);
    logic [APB_DATA_WIDTH-1:0] unused;
    apb_access(1'b1, idx, APB_DATA_WIDTH'(a), unused);
    if (idx < AXES) tracker.load_angle(idx, a);
    // let the sine sequencer pick up the write before polling busy
    repeat (2) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic check_angles();
    logic [APB_DATA_WIDTH-1:0] got;
    for (int i = 0; i < AXES; i++) begin
      apb_access(1'b0, i, '0, got);
      if (got !== APB_DATA_WIDTH'(tracker.angle[i])) begin
        $display("%0t: angle register %0d expected %0d, actual %0d", $time, i,
                 tracker.angle[i], got);
        tracker.mismatches++;
      end
    end
  endtask

  task automatic run_directed();
    logic signed [COORD_WIDTH-1:0] pts [5][3];
    pts = '{
      '{COORD_TOP, COORD_TOP, COORD_TOP},
      '{COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM},
      '{COORD_TOP, COORD_BOTTOM, 1},
      '{-1, 1, 0},
      '{COORD_BOTTOM, COORD_TOP, -32768}
    };
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 5; j++)
        send_point(axis_t'(k), pts[j][0], pts[j][1], pts[j][2]);
  endtask

  task automatic run_random(int count, int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain_results();
      send_point(pick_axis(), pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  initial begin
    tracker.clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_angles();
    // reset angles: the unit scale sits one step below one
    run_random(RANDOM_PER_SET, -1);
    for (int set = 0; set < SET_COUNT; set++) begin
      drain_results();
      for (int a = REG_ANGLE_X; a <= REG_ANGLE_Z; a++)
        set_angle(a, (set < 4) ? FIXED_ANGLES[set][a] : ANGLE_WIDTH'($urandom));
      // the spare address must leave every angle alone
      if (set == 0) set_angle(REG_SPARE, 16'h5A5A);
      check_angles();
      if (set == 0) run_directed();
      no_gaps = (set == 3);
      run_random(RANDOM_PER_SET, (set == 5) ? RANDOM_PER_SET / 2 : -1);
    end
    drain_results();
    if (tracker.mismatches == 0 && tracker.outstanding() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/arot_pkg.sv
rtl/arot_trig_unit.sv
rtl/arot_mix_lane.sv
rtl/arot_pipe.sv
rtl/axis_rotation_3d_unit.sv
sim/tb.sv
